// File: src/blocked_histogram_binner_unit_macros.svh
// Assertion macros for the blocked histogram binner checker.
// Used by bhb_checker only; no other dependencies.
`ifndef BLOCKED_HISTOGRAM_BINNER_UNIT_MACROS_SVH
`define BLOCKED_HISTOGRAM_BINNER_UNIT_MACROS_SVH
// Checked property, ignored while reset is asserted.
`define BHB_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked property that also holds through reset.
`define BHB_CHECK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

// File: src/bhb_pkg.sv
// Package for the blocked histogram binner: field widths, mode and op codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bhb_pkg;
    localparam int NUM_EIGS_DEF   = 8;
    localparam int NUM_BREAKS_DEF = 15;
    localparam int MAX_BLOCKS_DEF = 16;

    localparam int MODE_W  = 3;
    localparam int EIG_W   = 3;
    localparam int POS_W   = 16;
    localparam int DATA_W  = 32;
    localparam int LEVEL_W = 4;
    localparam int SUM_W   = 48;
    localparam int CFG_W   = 5;
    localparam int NB_RESET = 16;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HIST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SUM   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_HIST  = 2'd1;
    localparam logic [OP_W-1:0] OP_SUM   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic init_busy;
    } t_back_status;
endpackage
`default_nettype wire

// File: src/blocked_histogram_binner_unit.sv
// Top level of the blocked histogram binner: config register, front, queue, back.
// Depends on bhb_pkg, bhb_front, bhb_queue, bhb_back.
//
// Input words arrive on i_in_valid / o_in_ready with mode, eig_index, position
// and sample_value; result words leave on o_out_valid / i_out_ready. The block
// count is written through i_cfg_we / i_cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this. A break
// load is written into the break memory as the front accepts it. For a sample
// add the front works out the block remainder four position bits per cycle and
// then hands the word to the queue; the back then reads the histogram and sum
// memories in B_ADD_RD and writes them back in B_ADD_WR. A histogram read
// yields NUM_BREAKS+1 words, one per level, each from a registered memory read;
// a block sum read yields one word. After reset, and after a clear word, the
// back sweeps the histogram and sum memories one entry per cycle, over
// 2**(block bits + eig bits + level bits) entries (2048 at the default size);
// o_in_ready stays low during the sweep after reset as well as during a clear.
// When the receiver stalls, the result register holds its word and the back
// waits, while the queue still lets the front accept and prepare further words.
`timescale 1ns / 1ps
`default_nettype none
module blocked_histogram_binner_unit import bhb_pkg::*; #(
    parameter int NUM_EIGS   = NUM_EIGS_DEF,
    parameter int NUM_BREAKS = NUM_BREAKS_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [EIG_W-1:0]     i_eig_index,
    input  wire logic [POS_W-1:0]     i_position,
    input  wire logic signed [DATA_W-1:0] i_sample_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [LEVEL_W-1:0]        o_level,
    output logic [DATA_W-1:0]         o_cumulative_count,
    output logic signed [SUM_W-1:0]   o_block_sum,
    output logic [DATA_W-1:0]         o_sample_total,
    output logic                      o_last
);
    localparam int EW = (NUM_EIGS > 1) ? $clog2(NUM_EIGS) : 1;
    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LW = $clog2(NUM_BREAKS + 1);
    localparam int NW = $clog2(MAX_BLOCKS + 1);
    localparam int QW = OP_W + 1 + EW + BW + LW + DATA_W;

    logic [CFG_W-1:0] r_num_blocks;
    logic [NW-1:0]    nb_eff;
    logic             push_valid, push_ready, pop_valid, pop;
    logic [QW-1:0]    push_data, pop_data;
    t_back_status     back_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_blocks <= CFG_W'(NB_RESET);
        end else if (i_cfg_we) begin
            r_num_blocks <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_num_blocks == '0) begin
            nb_eff = NW'(1);
        end else if (32'(r_num_blocks) > MAX_BLOCKS) begin
            nb_eff = NW'(MAX_BLOCKS);
        end else begin
            nb_eff = NW'(r_num_blocks);
        end
    end

    bhb_front #(
        .NUM_EIGS(NUM_EIGS), .NUM_BREAKS(NUM_BREAKS), .MAX_BLOCKS(MAX_BLOCKS), .QW(QW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_eig_index   (i_eig_index),
        .i_position    (i_position),
        .i_sample_value(i_sample_value),
        .i_nb_eff      (nb_eff),
        .i_hold        (back_status.init_busy),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_data   (push_data)
    );

    bhb_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(push_valid),
        .o_push_ready(push_ready),
        .i_push_data (push_data),
        .o_pop_valid (pop_valid),
        .i_pop       (pop),
        .o_pop_data  (pop_data)
    );

    bhb_back #(
        .NUM_EIGS(NUM_EIGS), .NUM_BREAKS(NUM_BREAKS), .MAX_BLOCKS(MAX_BLOCKS), .QW(QW)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pop_valid       (pop_valid),
        .o_pop             (pop),
        .i_pop_data        (pop_data),
        .o_status          (back_status),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_level           (o_level),
        .o_cumulative_count(o_cumulative_count),
        .o_block_sum       (o_block_sum),
        .o_sample_total    (o_sample_total),
        .o_last            (o_last)
    );
endmodule
`default_nettype wire

// File: src/bhb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [AW-1:0]            i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [AW-1:0]            i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// File: src/bhb_front.sv
// Front part: accepts words, loads break values, finds block and bin of samples.
// Depends on bhb_pkg and bhb_ram.
`timescale 1ns / 1ps
`default_nettype none
module bhb_front import bhb_pkg::*; #(
    parameter int NUM_EIGS   = NUM_EIGS_DEF,
    parameter int NUM_BREAKS = NUM_BREAKS_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int QW         = 8,
    localparam int NW        = $clog2(MAX_BLOCKS + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [EIG_W-1:0]     i_eig_index,
    input  wire logic [POS_W-1:0]     i_position,
    input  wire logic [DATA_W-1:0]    i_sample_value,
    input  wire logic [NW-1:0]        i_nb_eff,
    input  wire logic                 i_hold,
    output logic                      o_push_valid,
    input  wire logic                 i_push_ready,
    output logic [QW-1:0]             o_push_data
);
    localparam int EW = (NUM_EIGS > 1) ? $clog2(NUM_EIGS) : 1;
    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LW = $clog2(NUM_BREAKS + 1);
    localparam int MOD_BITS = 4;
    localparam int MOD_STEPS = POS_W / MOD_BITS;
    localparam int MSW = $clog2(MOD_STEPS);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MOD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [OP_W-1:0]   r_kind, n_kind;
    logic              r_ok, n_ok;
    logic [EW-1:0]     r_eig, n_eig;
    logic [BW-1:0]     r_blk, n_blk;
    logic [DATA_W-1:0] r_val, n_val;
    logic [NW-1:0]     r_rem, n_rem;
    logic [POS_W-1:0]  r_quo, n_quo;
    logic [MSW-1:0]    r_cnt, n_cnt;
    logic [NUM_BREAKS-1:0] r_gt;

    logic [DATA_W-1:0] brk [NUM_BREAKS];
    logic              accept, eig_ok, load_ok, pos_ok;
    logic [NW-1:0]     step_rem;
    logic [NW:0]       trial;
    logic [POS_W-1:0]  step_quo;
    logic [LW-1:0]     bin;

    assign o_in_ready = (r_state == F_IDLE) && !i_hold;
    assign accept  = i_in_valid && o_in_ready;
    assign eig_ok  = 32'(i_eig_index) < NUM_EIGS;
    assign load_ok = eig_ok && (32'(i_position) < NUM_BREAKS);
    assign pos_ok  = 32'(i_position) < 32'(i_nb_eff);

    for (genvar j = 0; j < NUM_BREAKS; j++) begin : g_lane
        bhb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_EIGS)) u_brk (
            .i_clk    (i_clk),
            .i_wr_en  (accept && (i_mode == MODE_LOAD) && load_ok
                       && (i_position == POS_W'(j))),
            .i_wr_addr(EW'(i_eig_index)),
            .i_wr_data(i_sample_value),
            .i_rd_addr(r_eig),
            .o_rd_data(brk[j])
        );
    end

    always_comb begin
        step_rem = r_rem;
        step_quo = r_quo;
        trial = '0;
        for (int b = 0; b < MOD_BITS; b++) begin
            trial = {step_rem, step_quo[POS_W-1]};
            step_quo = {step_quo[POS_W-2:0], 1'b0};
            if (trial >= {1'b0, i_nb_eff}) begin
                trial = trial - {1'b0, i_nb_eff};
            end
            step_rem = trial[NW-1:0];
        end
    end

    always_comb begin
        bin = '0;
        for (int j = 0; j < NUM_BREAKS; j++) begin
            bin = bin + LW'(r_gt[j]);
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_ok    = r_ok;
        n_eig   = r_eig;
        n_blk   = r_blk;
        n_val   = r_val;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_eig = EW'(i_eig_index);
                    n_val = i_sample_value;
                    n_ok  = eig_ok && pos_ok;
                    n_blk = BW'(i_position);
                    case (i_mode)
                        MODE_ADD: begin
                            if (eig_ok) begin
                                n_kind  = OP_ADD;
                                n_rem   = '0;
                                n_quo   = i_position;
                                n_cnt   = '0;
                                n_state = F_MOD;
                            end
                        end
                        MODE_HIST: begin
                            n_kind  = OP_HIST;
                            n_state = F_PUSH;
                        end
                        MODE_SUM: begin
                            n_kind  = OP_SUM;
                            n_state = F_PUSH;
                        end
                        MODE_CLEAR: begin
                            n_kind  = OP_CLEAR;
                            n_state = F_PUSH;
                        end
                        default: begin
                            n_state = F_IDLE;
                        end
                    endcase
                end
            end
            F_MOD: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MSW'(MOD_STEPS - 1)) begin
                    n_blk   = BW'(step_rem);
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_push_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_kind <= n_kind;
        r_ok   <= n_ok;
        r_eig  <= n_eig;
        r_blk  <= n_blk;
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        for (int j = 0; j < NUM_BREAKS; j++) begin
            r_gt[j] <= $signed(r_val) > $signed(brk[j]);
        end
    end

    assign o_push_valid = (r_state == F_PUSH);
    assign o_push_data  = {r_kind, r_ok, r_eig, r_blk, bin, r_val};
endmodule
`default_nettype wire

// File: src/bhb_queue.sv
// Short queue between the front and back parts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bhb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW:0]      r_wr, r_rd;
    logic             do_push, do_pop;

    assign o_pop_valid  = (r_wr != r_rd);
    assign o_push_ready = (r_wr[PW-1:0] != r_rd[PW-1:0]) || (r_wr[PW] == r_rd[PW]);
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;
    assign o_pop_data   = r_slot[r_rd[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
        if (do_push) begin
            r_slot[r_wr[PW-1:0]] <= i_push_data;
        end
    end
endmodule
`default_nettype wire

// File: src/bhb_back.sv
// Back part: histogram and sum updates, read runs, clearing sweep, result register.
// Depends on bhb_pkg and bhb_ram.
`timescale 1ns / 1ps
`default_nettype none
module bhb_back import bhb_pkg::*; #(
    parameter int NUM_EIGS   = NUM_EIGS_DEF,
    parameter int NUM_BREAKS = NUM_BREAKS_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int QW         = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_pop_valid,
    output logic                      o_pop,
    input  wire logic [QW-1:0]        i_pop_data,
    output t_back_status              o_status,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [LEVEL_W-1:0]        o_level,
    output logic [DATA_W-1:0]         o_cumulative_count,
    output logic signed [SUM_W-1:0]   o_block_sum,
    output logic [DATA_W-1:0]         o_sample_total,
    output logic                      o_last
);
    localparam int EW  = (NUM_EIGS > 1) ? $clog2(NUM_EIGS) : 1;
    localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LW  = $clog2(NUM_BREAKS + 1);
    localparam int SAW = BW + EW;
    localparam int HAW = SAW + LW;

    localparam logic [2:0] B_INIT   = 3'd0;
    localparam logic [2:0] B_IDLE   = 3'd1;
    localparam logic [2:0] B_ADD_RD = 3'd2;
    localparam logic [2:0] B_ADD_WR = 3'd3;
    localparam logic [2:0] B_HR_RD  = 3'd4;
    localparam logic [2:0] B_HR_OUT = 3'd5;
    localparam logic [2:0] B_SR_RD  = 3'd6;
    localparam logic [2:0] B_SR_OUT = 3'd7;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic [OP_W-1:0]   e_kind;
    logic              e_ok;
    logic [EW-1:0]     e_eig;
    logic [BW-1:0]     e_blk;
    logic [LW-1:0]     e_bin;
    logic [DATA_W-1:0] e_val;

    logic [2:0]        r_state, n_state;
    logic              r_ok;
    logic [EW-1:0]     r_eig;
    logic [BW-1:0]     r_blk;
    logic [LW-1:0]     r_lvl, n_lvl;
    logic [DATA_W-1:0] r_val;
    logic [HAW-1:0]    r_clr, n_clr;
    logic [DATA_W-1:0] r_seen, n_seen;
    logic [DATA_W-1:0] r_cum, n_cum;

    logic              r_out_valid, n_out_valid;
    logic [LW-1:0]     r_out_lvl, n_out_lvl;
    logic [DATA_W-1:0] r_out_cum, n_out_cum;
    logic [SUM_W-1:0]  r_out_sum, n_out_sum;
    logic [DATA_W-1:0] r_out_tot, n_out_tot;
    logic              r_out_last, n_out_last;

    logic [DATA_W-1:0] hist_q, hist_wd;
    logic [SUM_W-1:0]  sum_q, sum_wd;
    logic              hist_we, sum_we;
    logic [HAW-1:0]    hist_addr, hist_wa;
    logic [SAW-1:0]    sum_addr, sum_wa;
    logic [SUM_W:0]    sum_ext;
    logic [DATA_W:0]   cum_ext;
    logic              slot_free;

    assign {e_kind, e_ok, e_eig, e_blk, e_bin, e_val} = i_pop_data;

    assign hist_addr = {r_blk, r_eig, r_lvl};
    assign sum_addr  = {r_blk, r_eig};
    assign hist_wa   = (r_state == B_INIT) ? r_clr : hist_addr;
    assign sum_wa    = (r_state == B_INIT) ? r_clr[SAW-1:0] : sum_addr;
    assign hist_we   = (r_state == B_INIT) || (r_state == B_ADD_WR);
    assign sum_we    = hist_we;
    assign hist_wd   = (r_state == B_INIT) ? '0
                     : ((hist_q == '1) ? hist_q : hist_q + 1'b1);
    assign sum_ext   = $signed({sum_q[SUM_W-1], sum_q})
                     + $signed({{(SUM_W-DATA_W+1){r_val[DATA_W-1]}}, r_val});
    always_comb begin
        if (r_state == B_INIT) begin
            sum_wd = '0;
        end else if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_wd = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_wd = sum_ext[SUM_W-1:0];
        end
    end
    assign cum_ext   = {1'b0, r_cum} + {1'b0, hist_q};
    assign slot_free = !r_out_valid || i_out_ready;

    bhb_ram #(.WIDTH(DATA_W), .DEPTH(2 ** HAW)) u_hist (
        .i_clk    (i_clk),
        .i_wr_en  (hist_we),
        .i_wr_addr(hist_wa),
        .i_wr_data(hist_wd),
        .i_rd_addr(hist_addr),
        .o_rd_data(hist_q)
    );

    bhb_ram #(.WIDTH(SUM_W), .DEPTH(2 ** SAW)) u_sum (
        .i_clk    (i_clk),
        .i_wr_en  (sum_we),
        .i_wr_addr(sum_wa),
        .i_wr_data(sum_wd),
        .i_rd_addr(sum_addr),
        .o_rd_data(sum_q)
    );

    assign o_pop = (r_state == B_IDLE) && i_pop_valid;

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_clr       = r_clr;
        n_seen      = r_seen;
        n_cum       = r_cum;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_lvl   = r_out_lvl;
        n_out_cum   = r_out_cum;
        n_out_sum   = r_out_sum;
        n_out_tot   = r_out_tot;
        n_out_last  = r_out_last;
        case (r_state)
            B_INIT: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_pop_valid) begin
                    n_lvl = e_bin;
                    n_cum = '0;
                    case (e_kind)
                        OP_ADD:   n_state = B_ADD_RD;
                        OP_HIST: begin
                            n_lvl   = '0;
                            n_state = B_HR_RD;
                        end
                        OP_SUM:   n_state = B_SR_RD;
                        OP_CLEAR: begin
                            n_clr   = '0;
                            n_seen  = '0;
                            n_state = B_INIT;
                        end
                        default:  n_state = B_IDLE;
                    endcase
                end
            end
            B_ADD_RD: begin
                n_state = B_ADD_WR;
            end
            B_ADD_WR: begin
                if (r_eig == '0 && r_seen != '1) begin
                    n_seen = r_seen + 1'b1;
                end
                n_state = B_IDLE;
            end
            B_HR_RD: begin
                n_state = B_HR_OUT;
            end
            B_HR_OUT: begin
                if (slot_free) begin
                    if (r_ok) begin
                        n_cum = cum_ext[DATA_W] ? '1 : cum_ext[DATA_W-1:0];
                    end
                    n_out_valid = 1'b1;
                    n_out_lvl   = r_lvl;
                    n_out_cum   = r_ok ? (cum_ext[DATA_W] ? '1 : cum_ext[DATA_W-1:0])
                                       : r_cum;
                    n_out_sum   = '0;
                    n_out_tot   = r_seen;
                    n_out_last  = (r_lvl == LW'(NUM_BREAKS));
                    if (r_lvl == LW'(NUM_BREAKS)) begin
                        n_state = B_IDLE;
                    end else begin
                        n_lvl   = r_lvl + 1'b1;
                        n_state = B_HR_RD;
                    end
                end
            end
            B_SR_RD: begin
                n_state = B_SR_OUT;
            end
            B_SR_OUT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_lvl   = '0;
                    n_out_cum   = '0;
                    n_out_sum   = r_ok ? sum_q : '0;
                    n_out_tot   = r_seen;
                    n_out_last  = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_INIT;
            r_clr       <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
        if (o_pop) begin
            r_ok  <= e_ok;
            r_eig <= e_eig;
            r_blk <= e_blk;
            r_val <= e_val;
        end
        r_lvl      <= n_lvl;
        r_cum      <= n_cum;
        r_out_lvl  <= n_out_lvl;
        r_out_cum  <= n_out_cum;
        r_out_sum  <= n_out_sum;
        r_out_tot  <= n_out_tot;
        r_out_last <= n_out_last;
    end

    assign o_status.init_busy = (r_state == B_INIT);
    assign o_out_valid        = r_out_valid;
    assign o_level            = LEVEL_W'(r_out_lvl);
    assign o_cumulative_count = r_out_cum;
    assign o_block_sum        = r_out_sum;
    assign o_sample_total     = r_out_tot;
    assign o_last             = r_out_last;
endmodule
`default_nettype wire

// File: src/bhb_checker.sv
// Port-level checker for the blocked histogram binner, bound to the top level.
// Depends on bhb_pkg and blocked_histogram_binner_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "blocked_histogram_binner_unit_macros.svh"
module bhb_checker import bhb_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [LEVEL_W-1:0]   o_level,
    input wire logic [DATA_W-1:0]    o_cumulative_count,
    input wire logic [SUM_W-1:0]     o_block_sum,
    input wire logic                 o_last
);
    `BHB_CHECK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_level) && $stable(o_cumulative_count) && $stable(o_block_sum), "Result word changed while stalled.")
    `BHB_CHECK_RST(a_reset_sweep, !i_rst_n |=> !o_in_ready, "Input ready during the reset sweep.")
    `BHB_CHECK(a_hist_no_sum, o_out_valid && !o_last |-> o_block_sum == '0, "Histogram word carries a sum.")
    `BHB_CHECK(a_sum_fields, o_out_valid && o_block_sum != '0 |-> o_last && o_level == '0 && o_cumulative_count == '0, "Sum word carries histogram fields.")
endmodule

bind blocked_histogram_binner_unit bhb_checker u_bhb_checker (.*);
`default_nettype wire

// File: sim/bhb_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the blocked histogram binner: keeps its own copy of the break,
// histogram and sum stores, predicts every result word and compares it field by field.
// Depends on bhb_pkg.
module bhb_result_checker import bhb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [EIG_W-1:0]         i_eig_index,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_sample_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [LEVEL_W-1:0]       i_level,
    input  logic [DATA_W-1:0]        i_cumulative_count,
    input  logic signed [SUM_W-1:0]  i_block_sum,
    input  logic [DATA_W-1:0]        i_sample_total,
    input  logic                     i_last,
    output int                       o_fail_count,
    output int                       o_pending
);
    localparam int NEIG = NUM_EIGS_DEF;
    localparam int NBRK = NUM_BREAKS_DEF;
    localparam int NBLK = MAX_BLOCKS_DEF;
    localparam longint SUM_TOP = 64'sh7FFF_FFFF_FFFF;
    localparam longint SUM_BOTTOM = -SUM_TOP - 1;

    typedef struct {
        logic [LEVEL_W-1:0]       level;
        logic [DATA_W-1:0]        cum;
        logic signed [SUM_W-1:0]  sum;
        logic [DATA_W-1:0]        total;
        logic                     last;
    } bin_word_t;

    bin_word_t                expected_words[$];
    logic signed [DATA_W-1:0] break_vals[NEIG][NBRK];
    logic [DATA_W-1:0]        bin_counts[NBLK][NEIG][NBRK+1];
    logic signed [SUM_W-1:0]  blk_sums[NBLK][NEIG];
    logic [DATA_W-1:0]        eig0_seen;
    logic [CFG_W-1:0]         blocks_cfg;

    task automatic clear_stores();
        foreach (bin_counts[b, e, l]) bin_counts[b][e][l] = '0;
        foreach (blk_sums[b, e]) blk_sums[b][e] = '0;
        eig0_seen = '0;
    endtask

    task automatic bin_word(input logic [MODE_W-1:0] mode, input int eig, input int pos,
                            input logic signed [DATA_W-1:0] val);
        int eff;
        int blk;
        int bin;
        longint acc;
        bin_word_t w;
        eff = (blocks_cfg == 0) ? 1 : ((blocks_cfg > NBLK) ? NBLK : int'(blocks_cfg));
        case (mode)
            MODE_LOAD: begin
                if (pos < NBRK) break_vals[eig][pos] = val;
            end
            MODE_ADD: begin
                blk = pos % eff;
                bin = 0;
                for (int j = 0; j < NBRK; j++) if (val > break_vals[eig][j]) bin++;
                if (bin_counts[blk][eig][bin] != '1) bin_counts[blk][eig][bin]++;
                acc = longint'(blk_sums[blk][eig]) + longint'(val);
                if (acc > SUM_TOP) acc = SUM_TOP;
                if (acc < SUM_BOTTOM) acc = SUM_BOTTOM;
                blk_sums[blk][eig] = acc[SUM_W-1:0];
                if (eig == 0 && eig0_seen != '1) eig0_seen++;
            end
            MODE_HIST: begin
                acc = 0;
                for (int l = 0; l <= NBRK; l++) begin
                    if (pos < eff) begin
                        acc += bin_counts[pos][eig][l];
                        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
                    end
                    w.level = l[LEVEL_W-1:0];
                    w.cum = acc[DATA_W-1:0];
                    w.sum = '0;
                    w.total = eig0_seen;
                    w.last = (l == NBRK);
                    expected_words.push_back(w);
                end
            end
            MODE_SUM: begin
                w.level = '0;
                w.cum = '0;
                w.sum = (pos < eff) ? blk_sums[pos][eig] : '0;
                w.total = eig0_seen;
                w.last = 1'b1;
                expected_words.push_back(w);
            end
            MODE_CLEAR: clear_stores();
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        bin_word_t w;
        if (!i_rst_n) begin
            clear_stores();
            blocks_cfg = CFG_W'(NB_RESET);
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word, level %h count %h sum %h",
                             $time, i_level, i_cumulative_count, i_block_sum);
                    o_fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("level", w.level, i_level);
                    check_field("cumulative_count", w.cum, i_cumulative_count);
                    check_field("block_sum", w.sum, i_block_sum);
                    check_field("sample_total", w.total, i_sample_total);
                    check_field("last", w.last, i_last);
                end
            end
            if (i_in_valid && i_in_ready)
                bin_word(i_mode, i_eig_index, i_position, i_sample_value);
            if (i_cfg_we) blocks_cfg = i_cfg_data;
        end
        o_pending <= expected_words.size();
    end
endmodule

// File: sim/tb_blocked_histogram_binner_unit.sv
`timescale 1ns / 1ps
// Testbench top for the blocked histogram binner: clock, reset, directed and random
// stimulus, idle patterns and the verdict. Depends on bhb_pkg, the block and bhb_result_checker.
module tb_blocked_histogram_binner_unit import bhb_pkg::*;;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SWEEP_WAIT = 2300;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [MODE_W-1:0]        i_mode;
    logic [EIG_W-1:0]         i_eig_index;
    logic [POS_W-1:0]         i_position;
    logic signed [DATA_W-1:0] i_sample_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [LEVEL_W-1:0]       o_level;
    logic [DATA_W-1:0]        o_cumulative_count;
    logic signed [SUM_W-1:0]  o_block_sum;
    logic [DATA_W-1:0]        o_sample_total;
    logic                     o_last;
    int                       fail_count;
    int                       pending_words;
    int                       cycle_count;
    int                       send_idle_pct;
    int                       recv_idle_pct;
    int                       blocks_now;
    logic signed [DATA_W-1:0] stim_breaks[8][15];
    logic [14:0]              breaks_loaded[8];

    blocked_histogram_binner_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_mode(i_mode),
        .i_eig_index(i_eig_index), .i_position(i_position), .i_sample_value(i_sample_value),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_level(o_level),
        .o_cumulative_count(o_cumulative_count), .o_block_sum(o_block_sum),
        .o_sample_total(o_sample_total), .o_last(o_last)
    );

    bhb_result_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_mode(i_mode),
        .i_eig_index(i_eig_index), .i_position(i_position), .i_sample_value(i_sample_value),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_level(o_level),
        .i_cumulative_count(o_cumulative_count), .i_block_sum(o_block_sum),
        .i_sample_total(o_sample_total), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending_words)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            cycle_count <= 0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            cycle_count <= cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] mode, input int eig, input int pos,
                             input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_eig_index <= eig[EIG_W-1:0];
        i_position <= pos[POS_W-1:0];
        i_sample_value <= val;
        if (mode == MODE_LOAD && pos < 15) begin
            stim_breaks[eig][pos] = val;
            breaks_loaded[eig][pos] = 1'b1;
        end
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_blocks(input int value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (SWEEP_WAIT) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        blocks_now = (value == 0) ? 1 : ((value > 16) ? 16 : value);
    endtask

    task automatic pick_value(input int eig, output logic signed [DATA_W-1:0] val);
        int r;
        r = $urandom_range(9);
        if (r < 3 && breaks_loaded[eig] == '1)
            val = stim_breaks[eig][$urandom_range(14)] + $urandom_range(2) - 1;
        else if (r == 3)
            val = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        else
            val = $urandom;
    endtask

    task automatic random_word(output bit counted);
        int r;
        int eig;
        int pos;
        logic signed [DATA_W-1:0] val;
        r = $urandom_range(99);
        eig = $urandom_range(7);
        pick_value(eig, val);
        counted = 1'b1;
        if (r < 22) begin
            pos = ($urandom_range(9) == 0) ? $urandom_range(65535, 15) : $urandom_range(14);
            counted = (pos < 15);
            send_word(MODE_LOAD, eig, pos, val);
        end else if (r < 70) begin
            if (breaks_loaded[eig] != '1) eig = 0;
            pick_value(eig, val);
            send_word(MODE_ADD, eig, $urandom_range(65535), val);
        end else if (r < 94) begin
            pos = ($urandom_range(7) == 0) ? $urandom_range(65535)
                                           : $urandom_range(blocks_now - 1);
            send_word((r < 82) ? MODE_HIST : MODE_SUM, eig, pos, val);
        end else if (r < 97) begin
            send_word(MODE_CLEAR, eig, $urandom_range(65535), val);
        end else begin
            counted = 1'b0;
            send_word(MODE_W'($urandom_range(7, 5)), eig, $urandom_range(65535), val);
        end
    endtask

    task automatic random_phase(input int sender_pct, input int receiver_pct,
                                input int blocks, input int count);
        int n;
        bit counted;
        write_blocks(blocks);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        n = 0;
        while (n < count) begin
            random_word(counted);
            if (counted) n++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = '0;
        i_eig_index = '0;
        i_position = '0;
        i_sample_value = '0;
        blocks_now = 16;
        send_idle_pct = 16;
        recv_idle_pct = 50;
        foreach (breaks_loaded[e]) breaks_loaded[e] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_blocks(3);
        send_word(MODE_LOAD, 0, 0, 32'sh8000_0000);
        send_word(MODE_LOAD, 0, 1, 32'sh7FFF_FFFF);
        for (int j = 2; j < 15; j++) send_word(MODE_LOAD, 0, j, (14 - j) * 32'sh0001_0000);
        send_word(MODE_LOAD, 0, 15, 32'sh1234_5678);
        send_word(MODE_LOAD, 7, 65535, 32'sh0);
        send_word(MODE_ADD, 0, 65535, 32'sh8000_0000);
        send_word(MODE_ADD, 0, 0, 32'sh7FFF_FFFF);
        send_word(MODE_ADD, 0, 4, 32'sh0003_0000);
        send_word(MODE_ADD, 0, 2, 32'sh0003_0001);
        send_word(MODE_HIST, 0, 0, 32'sh0);
        send_word(MODE_SUM, 0, 0, 32'sh0);
        send_word(MODE_HIST, 0, 65535, 32'sh0);
        send_word(MODE_SUM, 7, 3, 32'sh0);
        send_word(3'd5, 7, 65535, 32'shFFFF_FFFF);
        send_word(3'd6, 0, 0, 32'sh0);
        send_word(3'd7, 0, 0, 32'sh0);
        send_word(MODE_CLEAR, 0, 0, 32'sh0);
        send_word(MODE_SUM, 0, 0, 32'sh0);

        random_phase(16, 50, 1, 45);
        random_phase(16, 50, 31, 45);
        random_phase(50, 16, 0, 45);
        random_phase(50, 16, 16, 45);
        random_phase(0, 0, 7, 80);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: blocked_histogram_binner_unit.f
+incdir+src
src/bhb_pkg.sv
src/bhb_ram.sv
src/bhb_front.sv
src/bhb_queue.sv
src/bhb_back.sv
src/blocked_histogram_binner_unit.sv
src/bhb_checker.sv
sim/bhb_result_checker.sv
sim/tb_blocked_histogram_binner_unit.sv
